### src/dcmf_pkg.sv
// Shared constants, types and helpers of the dark channel minimum filter.
package dcmf_pkg;

  localparam int DIM_W          = 12;
  localparam int ROW_W          = 11;
  localparam int COL_W          = 12;
  localparam int POS_W          = 14;
  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_HEIGHT     = 2048;
  localparam int PATCH_SIZE_DEF = 15;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int REQ_DEPTH      = 4;
  localparam int OQ_DEPTH       = 8;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } req_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] data;
  } pix_wr_t;

  function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

### src/dcmf_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module dcmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/dcmf_fifo.sv
// Small register FIFO used for the request queue and the result queue.
module dcmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### src/dcmf_front.sv
// Front end: accepts items, stores pixel minima and issues result requests.
module dcmf_front import dcmf_pkg::*; #(
  parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dims_t            dims,
  input  logic             restart,
  input  logic             in_push,
  input  logic             in_cmd,
  input  logic [PIX_W-1:0] in_blue,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_red,
  output logic             in_full,
  input  logic             req_full,
  input  logic             req_empty,
  output logic             req_push,
  output req_t             req,
  output pix_wr_t          wr
);

  localparam int AHEAD = PATCH_SIZE - 1 - PATCH_SIZE / 2;

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic             in_done_r, in_done_nxt, hold_r, hold_nxt;
  logic             accept, pix, rdy, lst;
  logic [POS_W-1:0] w14, h14, nc, nr, tr, tc, ic14, ir14, oc14, or14;
  logic             nd;

  assign in_full = req_full | hold_r;
  assign accept  = in_push & ~in_full;
  assign pix     = accept & ~in_cmd & ~in_done_r;

  always_comb begin
    w14  = POS_W'(dims.width);
    h14  = POS_W'(dims.height);
    ic14 = POS_W'(in_col_r);
    ir14 = POS_W'(in_row_r);
    oc14 = POS_W'(out_col_r);
    or14 = POS_W'(out_row_r);
    nc   = ic14;
    nr   = ir14;
    nd   = in_done_r;
    if (pix) begin
      if (ic14 + 1'b1 >= w14) begin
        nc = '0;
        if (ir14 + 1'b1 >= h14) begin
          nr = '0;
          nd = 1'b1;
        end else begin
          nr = ir14 + 1'b1;
        end
      end else begin
        nc = ic14 + 1'b1;
      end
    end
    tr = or14 + POS_W'(AHEAD);
    if (tr > h14 - 1'b1) tr = h14 - 1'b1;
    tc = oc14 + POS_W'(AHEAD);
    if (tc > w14 - 1'b1) tc = w14 - 1'b1;
    rdy = accept && (nd || (tr < nr) || ((tr == nr) && (tc < nc)));
    lst = (or14 == h14 - 1'b1) && (oc14 == w14 - 1'b1);

    in_col_nxt  = nc[COL_W-1:0];
    in_row_nxt  = nr[ROW_W-1:0];
    in_done_nxt = nd;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    hold_nxt    = req_empty ? 1'b0 : hold_r;
    if (rdy) begin
      if (lst) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        in_done_nxt = 1'b0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        hold_nxt    = 1'b1;
      end else if (oc14 + 1'b1 >= w14) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_done_nxt = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      hold_nxt    = 1'b0;
    end
  end

  assign req_push = rdy;
  assign req.row  = out_row_r;
  assign req.col  = out_col_r;
  assign req.last = lst;
  assign wr.en    = pix;
  assign wr.row   = in_row_r;
  assign wr.col   = in_col_r;
  assign wr.data  = min8(in_blue, min8(in_green, in_red));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_done_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      hold_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      in_done_r <= in_done_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      hold_r    <= hold_nxt;
    end
  end

endmodule

### src/dcmf_back.sv
// Back end: column fetch, vertical and horizontal minimum over the window.
module dcmf_back import dcmf_pkg::*; #(
  parameter int PATCH_SIZE = PATCH_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int SLOTS      = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dims_t                        dims,
  input  req_t                         req,
  input  logic                         req_empty,
  output logic                         req_pop,
  output logic [$clog2(MAX_WIDTH)-1:0] raddr,
  input  logic [PIX_W-1:0]             rdata [SLOTS],
  input  logic                         res_taken,
  output logic                         res_push,
  output logic [PIX_W-1:0]             res_dark,
  output logic                         res_last
);

  localparam int HALF   = PATCH_SIZE / 2;
  localparam int AHEAD  = PATCH_SIZE - 1 - HALF;
  localparam int SW     = $clog2(SLOTS);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int PCW    = $clog2(AHEAD + 1);
  localparam int GROUPS = SLOTS / 8;
  localparam int WG     = (PATCH_SIZE + 3) / 4;
  localparam int OCW    = $clog2(OQ_DEPTH + 1);

  logic [PCW-1:0]   pre_cnt_r, pre_cnt_nxt;
  logic [OCW-1:0]   oc_r, oc_nxt;
  logic             is_pre, can_final, issue;
  logic [POS_W-1:0] op_col, w14, h14;
  logic [SLOTS-1:0] mask;

  logic             v1_r, colok1_r, clear1_r, emit1_r, last1_r;
  logic [SLOTS-1:0] mask1_r;
  logic             v2_r, colok2_r, clear2_r, emit2_r, last2_r;
  logic [PIX_W-1:0] gm2_r [GROUPS];
  logic [PIX_W-1:0] gm_nxt [GROUPS];
  logic [PIX_W-1:0] win_r [PATCH_SIZE];
  logic [PIX_W-1:0] win_nxt [PATCH_SIZE];
  logic             emit3_r, last3_r, emit4_r, last4_r;
  logic [PIX_W-1:0] part4_r [WG];
  logic [PIX_W-1:0] part_nxt [WG];

  assign w14       = POS_W'(dims.width);
  assign h14       = POS_W'(dims.height);
  assign is_pre    = ~req_empty && (req.col == '0) && (pre_cnt_r < PCW'(AHEAD));
  assign can_final = ~req_empty && ~is_pre && (oc_r < OCW'(OQ_DEPTH));
  assign issue     = is_pre | can_final;
  assign req_pop   = can_final;
  assign op_col    = is_pre ? POS_W'(pre_cnt_r) : POS_W'(req.col) + POS_W'(AHEAD);
  assign raddr     = op_col[CW-1:0];

  always_comb begin
    logic [SW-1:0]    delta;
    logic [POS_W-1:0] rsum;
    for (int s = 0; s < SLOTS; s++) begin
      delta   = SW'(s) - req.row[SW-1:0] + SW'(HALF);
      rsum    = POS_W'(req.row) + POS_W'(delta);
      mask[s] = (delta < SW'(PATCH_SIZE)) && (rsum >= POS_W'(HALF)) &&
                (rsum <= h14 - 1'b1 + POS_W'(HALF));
    end
  end

  always_comb begin
    pre_cnt_nxt = pre_cnt_r;
    if (is_pre) begin
      pre_cnt_nxt = pre_cnt_r + 1'b1;
    end else if (can_final) begin
      pre_cnt_nxt = '0;
    end
    oc_nxt = oc_r;
    if (can_final && !res_taken) begin
      oc_nxt = oc_r + 1'b1;
    end else if (res_taken && !can_final) begin
      oc_nxt = oc_r - 1'b1;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] v;
    for (int g = 0; g < GROUPS; g++) begin
      gm_nxt[g] = PIX_MAX;
      for (int k = 0; k < 8; k++) begin
        v = mask1_r[g*8+k] ? rdata[g*8+k] : PIX_MAX;
        gm_nxt[g] = min8(gm_nxt[g], v);
      end
    end
  end

  always_comb begin
    logic [PIX_W-1:0] vcol;
    vcol = PIX_MAX;
    for (int g = 0; g < GROUPS; g++) begin
      vcol = min8(vcol, gm2_r[g]);
    end
    if (!colok2_r) vcol = PIX_MAX;
    for (int i = 0; i < PATCH_SIZE; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (v2_r) begin
      for (int i = 0; i < PATCH_SIZE - 1; i++) begin
        win_nxt[i] = clear2_r ? PIX_MAX : win_r[i+1];
      end
      win_nxt[PATCH_SIZE-1] = vcol;
    end
  end

  always_comb begin
    for (int q = 0; q < WG; q++) begin
      part_nxt[q] = PIX_MAX;
      for (int k = 0; k < 4; k++) begin
        if (q * 4 + k < PATCH_SIZE) begin
          part_nxt[q] = min8(part_nxt[q], win_r[q*4+k]);
        end
      end
    end
  end

  always_comb begin
    res_dark = PIX_MAX;
    for (int q = 0; q < WG; q++) begin
      res_dark = min8(res_dark, part4_r[q]);
    end
  end

  assign res_push = emit4_r;
  assign res_last = last4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r <= '0;
      oc_r      <= '0;
      v1_r      <= 1'b0;
      emit1_r   <= 1'b0;
      v2_r      <= 1'b0;
      emit2_r   <= 1'b0;
      emit3_r   <= 1'b0;
      emit4_r   <= 1'b0;
    end else begin
      pre_cnt_r <= pre_cnt_nxt;
      oc_r      <= oc_nxt;
      v1_r      <= issue;
      emit1_r   <= can_final;
      v2_r      <= v1_r;
      emit2_r   <= v1_r & emit1_r;
      emit3_r   <= v2_r & emit2_r;
      emit4_r   <= emit3_r;
    end
  end

  always_ff @(posedge clk) begin
    mask1_r  <= mask;
    colok1_r <= (op_col < w14);
    clear1_r <= is_pre && (pre_cnt_r == '0);
    last1_r  <= req.last;
    colok2_r <= colok1_r;
    clear2_r <= clear1_r;
    last2_r  <= last1_r;
    gm2_r    <= gm_nxt;
    win_r    <= win_nxt;
    last3_r  <= last2_r;
    part4_r  <= part_nxt;
    last4_r  <= last3_r;
  end

endmodule

### src/dark_channel_min_filter.sv
// Top level of the dark channel minimum filter.
// Result path: request queue, line-store read, group minimum, window and partial minimum
// registers, result queue; a row's first result also waits for the AHEAD (7) column prefetch.
// Throughput: one item per cycle; the input stalls while the request queue is full, and
// once a frame's last request is queued until that request is taken.
// Reset (rst_n low, synchronous) empties both queues and returns frame size to 640 x 480.
module dark_channel_min_filter import dcmf_pkg::*; #(
  parameter int PATCH_SIZE = PATCH_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_cmd,
  input  logic [PIX_W-1:0]     in_blue,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_red,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [PIX_W-1:0]     out_dark_value,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int SW    = $clog2(PATCH_SIZE + 17);
  localparam int SLOTS = 2 ** SW;
  localparam int CW    = $clog2(MAX_WIDTH);

  logic [DIM_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic             restart;
  dims_t            dims;
  req_t             req_in, req_out;
  pix_wr_t          wr;
  logic             req_push, req_full, req_empty, req_pop;
  logic [CW-1:0]    raddr;
  logic [PIX_W-1:0] rdata [SLOTS];
  logic             res_push, res_last, oq_full, res_taken;
  logic [PIX_W-1:0] res_dark;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          width_nxt = cfg_data;
          restart   = 1'b1;
        end
        CFG_FRAME_HEIGHT: begin
          height_nxt = cfg_data;
          restart    = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    dims.width = width_r;
    if (width_r == '0) begin
      dims.width = DIM_W'(1);
    end else if ({1'b0, width_r} > (DIM_W+1)'(MAX_WIDTH)) begin
      dims.width = DIM_W'(MAX_WIDTH);
    end
    dims.height = height_r;
    if (height_r == '0) begin
      dims.height = DIM_W'(1);
    end else if ({1'b0, height_r} > (DIM_W+1)'(MAX_HEIGHT)) begin
      dims.height = DIM_W'(MAX_HEIGHT);
    end
  end

  dcmf_front #(.PATCH_SIZE(PATCH_SIZE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .restart   (restart),
    .in_push   (in_push),
    .in_cmd    (in_cmd),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .in_full   (in_full),
    .req_full  (req_full),
    .req_empty (req_empty),
    .req_push  (req_push),
    .req       (req_in),
    .wr        (wr)
  );

  dcmf_fifo #(.WIDTH($bits(req_t)), .DEPTH(REQ_DEPTH)) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (req_push),
    .din   (req_in),
    .full  (req_full),
    .pop   (req_pop),
    .dout  (req_out),
    .empty (req_empty)
  );

  for (genvar s = 0; s < SLOTS; s++) begin : g_line
    dcmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (wr.en && (wr.row[SW-1:0] == SW'(s))),
      .waddr (wr.col[CW-1:0]),
      .wdata (wr.data),
      .raddr (raddr),
      .rdata (rdata[s])
    );
  end

  assign res_taken = out_pop & ~out_empty;

  dcmf_back #(.PATCH_SIZE(PATCH_SIZE), .MAX_WIDTH(MAX_WIDTH), .SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .req       (req_out),
    .req_empty (req_empty),
    .req_pop   (req_pop),
    .raddr     (raddr),
    .rdata     (rdata),
    .res_taken (res_taken),
    .res_push  (res_push),
    .res_dark  (res_dark),
    .res_last  (res_last)
  );

  dcmf_fifo #(.WIDTH(PIX_W + 1), .DEPTH(OQ_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   ({res_dark, res_last}),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  ({out_dark_value, out_frame_last}),
    .empty (out_empty)
  );

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !oq_full) else $error("result pushed into a full queue");

  a_req_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |-> !req_empty) else $error("request popped from an empty queue");

  a_pix_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (in_push && !in_full)) else $error("line store written without an item");

endmodule
